// File: src/mbss_pkg.sv
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared constants for the masked byte signature scanner: register map,
// extraction mode codes and reset values.
// ----------------------------------------------------------------------------
package mbss_pkg;

    localparam int PATTERN_MAX_DEF = 16;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [2:0]           mode_t;
    typedef logic [7:0]           byte_t;

    localparam reg_idx_t REG_PATTERN_LOW    = 3'd0;
    localparam reg_idx_t REG_PATTERN_HIGH   = 3'd1;
    localparam reg_idx_t REG_WILDCARD_MASK  = 3'd2;
    localparam reg_idx_t REG_PATTERN_LENGTH = 3'd3;
    localparam reg_idx_t REG_EXTRACT_MODE   = 3'd4;
    localparam reg_idx_t REG_BASE_ADDRESS   = 3'd5;

    localparam mode_t MODE_ADDR  = 3'd0;
    localparam mode_t MODE_REL1  = 3'd1;
    localparam mode_t MODE_REL2  = 3'd2;
    localparam mode_t MODE_WORD1 = 3'd3;
    localparam mode_t MODE_WORD2 = 3'd4;

    localparam logic [31:0] BASE_ADDRESS_RESET = 32'h0040_0000;
    localparam logic [31:0] REL1_BIAS          = 32'd5;
    localparam logic [31:0] REL2_BIAS          = 32'd6;

endpackage

// File: src/mbss_if.sv
// ----------------------------------------------------------------------------
// mbss_in_if / mbss_out_if
// Valid/ready channels of the scanner: memory bytes in, scan results out.
// ----------------------------------------------------------------------------
interface mbss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface mbss_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] value;

    modport source (output valid, output found, output value, input ready);
    modport sink   (input valid, input found, input value, output ready);
endinterface

// File: src/masked_byte_signature_scanner_core.sv
// ----------------------------------------------------------------------------
// masked_byte_signature_scanner_core
// Streams the bytes of a memory region and reports the first position where
// a wildcard byte pattern matches, as an address or an extracted word.
//
// The din channel takes one byte per item, with last set on the final byte
// of the region. The dout channel gives at most one item per region: found
// with the address or word selected by extract_mode, or not-found with value
// zero when the region ends without a match. Bytes after a match are ignored
// until the last byte, which starts a new region at base_address.
// Registers must be written over the APB port only while the block is idle;
// the block itself does not enforce it. An accepted byte enters the window
// register; the pattern compare and address add then load the result
// register, which drives dout. Throughput is one byte per cycle while dout
// takes each result, set by the single window compare stage.
// When dout stalls with a result waiting, the next byte stays in the window
// stage and din drops ready until the result is taken.
// Reset clears the region state and the output; registers take their
// documented reset values.
// ----------------------------------------------------------------------------
module masked_byte_signature_scanner_core
    import mbss_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    mbss_in_if.sink               din,
    mbss_out_if.source            dout
);

    localparam int IDX_W  = $clog2(PATTERN_MAX);
    localparam int SPAN_W = $clog2(PATTERN_MAX + 1);
    localparam logic [SPAN_W-1:0] PM_SPAN = SPAN_W'(PATTERN_MAX);

    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [15:0] wildcard_mask_reg;
    logic [4:0]  pattern_length_reg;
    mode_t       extract_mode_reg;
    logic [31:0] base_address_reg;

    byte_t       window_reg [PATTERN_MAX];
    byte_t       window_next [PATTERN_MAX];
    logic [31:0] bytes_seen_reg;
    logic [31:0] bytes_seen_next;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_last_reg;
    logic        match_done_reg;
    logic        match_done_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        found_reg;
    logic [31:0] value_reg;

    logic [127:0]      pattern_all;
    logic [SPAN_W-1:0] len;
    logic [SPAN_W-1:0] span;
    logic [SPAN_W-1:0] start;
    logic              hit;
    logic [31:0]       word1;
    logic [31:0]       word2;
    logic [31:0]       addr;
    logic [31:0]       match_value;
    logic              hit_eval;
    logic              emit;
    logic              adv;
    logic              accept;
    logic              region_end;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

    always_comb
    begin
        case (cfg_idx)
            REG_PATTERN_LOW:    prdata = pattern_low_reg;
            REG_PATTERN_HIGH:   prdata = pattern_high_reg;
            REG_WILDCARD_MASK:  prdata = {48'd0, wildcard_mask_reg};
            REG_PATTERN_LENGTH: prdata = {59'd0, pattern_length_reg};
            REG_EXTRACT_MODE:   prdata = {61'd0, extract_mode_reg};
            REG_BASE_ADDRESS:   prdata = {32'd0, base_address_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= '0;
            extract_mode_reg   <= MODE_ADDR;
            base_address_reg   <= BASE_ADDRESS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_PATTERN_LOW:    pattern_low_reg    <= pwdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= pwdata;
                REG_WILDCARD_MASK:  wildcard_mask_reg  <= pwdata[15:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[4:0];
                REG_EXTRACT_MODE:   extract_mode_reg   <= pwdata[2:0];
                REG_BASE_ADDRESS:   base_address_reg   <= pwdata[31:0];
                default:            ;
            endcase
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    always_comb
    begin
        if (pattern_length_reg > 5'(PATTERN_MAX))
            len = PM_SPAN;
        else
            len = pattern_length_reg[SPAN_W-1:0];

        span = len;
        case (extract_mode_reg)
            MODE_REL1, MODE_WORD1:
            begin
                if (span < SPAN_W'(5))
                    span = SPAN_W'(5);
            end
            MODE_REL2, MODE_WORD2:
            begin
                if (span < SPAN_W'(6))
                    span = SPAN_W'(6);
            end
            default: ;
        endcase
        if (span == '0)
            span = SPAN_W'(1);

        start = PM_SPAN - span;
    end

    always_comb
    begin
        logic [SPAN_W:0] pos;
        hit = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pos = (SPAN_W+1)'(start) + (SPAN_W+1)'(i);
            if ((SPAN_W'(i) < len) && !wildcard_mask_reg[i])
            begin
                if (window_reg[pos[IDX_W-1:0]] != pattern_all[8*i +: 8])
                    hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        logic [SPAN_W:0] pos1;
        logic [SPAN_W:0] pos2;
        word1 = '0;
        word2 = '0;
        for (int k = 0; k < 4; k++)
        begin
            pos1 = (SPAN_W+1)'(start) + (SPAN_W+1)'(k + 1);
            pos2 = (SPAN_W+1)'(start) + (SPAN_W+1)'(k + 2);
            if (pos1 < (SPAN_W+1)'(PATTERN_MAX))
                word1[8*k +: 8] = window_reg[pos1[IDX_W-1:0]];
            if (pos2 < (SPAN_W+1)'(PATTERN_MAX))
                word2[8*k +: 8] = window_reg[pos2[IDX_W-1:0]];
        end
    end

    assign addr = base_address_reg + bytes_seen_reg - 32'(span);

    always_comb
    begin
        case (extract_mode_reg)
            MODE_REL1:  match_value = word1 + addr + REL1_BIAS;
            MODE_REL2:  match_value = word2 + addr + REL2_BIAS;
            MODE_WORD1: match_value = word1;
            MODE_WORD2: match_value = word2;
            default:    match_value = addr;
        endcase
    end

    assign hit_eval = s1_valid_reg && !match_done_reg && (extract_mode_reg <= MODE_WORD2)
                      && (bytes_seen_reg >= 32'(span)) && hit;
    assign emit     = hit_eval || (s1_valid_reg && s1_last_reg && !match_done_reg);

    assign adv        = s1_valid_reg && (!out_valid_reg || dout.ready);
    assign din.ready  = !s1_valid_reg || adv;
    assign accept     = din.valid && din.ready;
    assign region_end = adv && s1_last_reg;

    always_comb
    begin
        bytes_seen_next = region_end ? '0 : bytes_seen_reg;
        window_next     = window_reg;
        if (accept)
        begin
            bytes_seen_next = bytes_seen_next + 32'd1;
            for (int i = 0; i + 1 < PATTERN_MAX; i++)
                window_next[i] = window_reg[i + 1];
            window_next[PATTERN_MAX-1] = din.data_byte;
        end

        if (accept)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (adv)
            match_done_next = s1_last_reg ? 1'b0 : (match_done_reg || hit_eval);
        else
            match_done_next = match_done_reg;

        if (adv)
            out_valid_next = emit;
        else if (dout.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            s1_valid_reg   <= 1'b0;
            match_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bytes_seen_reg <= bytes_seen_next;
            s1_valid_reg   <= s1_valid_next;
            match_done_reg <= match_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
        if (accept)
            s1_last_reg <= din.last;
        if (adv && emit)
        begin
            found_reg <= hit_eval;
            value_reg <= hit_eval ? match_value : 32'd0;
        end
    end

    assign dout.valid = out_valid_reg;
    assign dout.found = found_reg;
    assign dout.value = value_reg;

endmodule

// File: src/mbss_checker.sv
// ----------------------------------------------------------------------------
// mbss_checker
// Port-level checks for the masked byte signature scanner, bound to the top.
// ----------------------------------------------------------------------------
module mbss_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [31:0] value
);

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("Result shown after a reset edge.");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> value == 32'd0)
        else $error("Not-found result carries a nonzero value.");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("Result appeared without an item two cycles earlier.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(value))
        else $error("Stalled result changed or dropped.");

endmodule

bind masked_byte_signature_scanner_core mbss_checker u_mbss_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .found     (dout.found),
    .value     (dout.value)
);
